### design/lmfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix frame scanner package
// Shared constants, input kind codes and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lmfs_pkg;

  // Frame store geometry: 32 rows of 16 pixels.
  localparam int ROWS       = 32;
  localparam int ROW_W      = 16;
  localparam int ADDR_W     = 5;
  localparam int GROUP_ROWS = 8;

  // Input kind codes.
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_REFRESH = 2'd3;

  // Highest digit index and highest module slot of a refresh.
  localparam logic [2:0] LAST_INDEX = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic gather_step;
    logic ref_advance;
    logic wr_en;
    logic clear_store;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       bad;
    logic       k_done;
    logic       word_last;
    logic       out_free;
  } sts_t;

endpackage

### design/lmfs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one pixel, clear or refresh request a beat.
// ----------------------------------------------------------------------------
interface lmfs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic       pixel_value;

  modport source (output valid, output kind, output x_pos, output y_pos,
                  output pixel_value, input ready);
  modport sink (input valid, input kind, input x_pos, input y_pos,
                input pixel_value, output ready);
endinterface

### design/lmfs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one status answer or display word a beat.
// ----------------------------------------------------------------------------
interface lmfs_rsp_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic       pixel_bit;
  logic       coord_ignored;
  logic [3:0] digit_register;
  logic [7:0] segment_data;
  logic [2:0] module_slot;
  logic       last;

  modport source (output valid, output result_kind, output pixel_bit,
                  output coord_ignored, output digit_register,
                  output segment_data, output module_slot, output last,
                  input ready);
  modport sink (input valid, input result_kind, input pixel_bit,
                input coord_ignored, input digit_register,
                input segment_data, input module_slot, input last,
                output ready);
endinterface

### design/lmfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lmfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/lmfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame scanner controller
// Sequences pixel accesses, frame clears and the 64-word refresh walk.
// ----------------------------------------------------------------------------
module lmfs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    in_kind,
  output logic          in_ready,
  input  lmfs_pkg::sts_t sts,
  output lmfs_pkg::cmd_t cmd
);
  import lmfs_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PIX_RD  = 3'd1;
  localparam logic [2:0] ST_PIX_FIN = 3'd2;
  localparam logic [2:0] ST_CLR_FIN = 3'd3;
  localparam logic [2:0] ST_GATHER  = 3'd4;
  localparam logic [2:0] ST_EMIT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_kind)
            KIND_CLEAR:   state_next = ST_CLR_FIN;
            KIND_REFRESH: state_next = ST_GATHER;
            default:      state_next = ST_PIX_RD;
          endcase
        end
      end
      ST_PIX_RD: begin
        state_next = ST_PIX_FIN;
      end
      ST_PIX_FIN: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          cmd.wr_en  = (sts.kind == KIND_WRITE) && !sts.bad;
          state_next = ST_IDLE;
        end
      end
      ST_CLR_FIN: begin
        if (sts.out_free) begin
          cmd.load        = 1'b1;
          cmd.clear_store = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_GATHER: begin
        cmd.gather_step = 1'b1;
        if (sts.k_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load        = 1'b1;
          cmd.ref_advance = 1'b1;
          state_next      = sts.word_last ? ST_IDLE : ST_GATHER;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // An accepted request always starts work.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state != ST_IDLE)
    else $error("accepted request left the controller idle");

  // The store is written only by an in-range pixel write.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (state == ST_PIX_FIN) && (sts.kind == KIND_WRITE) && !sts.bad)
    else $error("store written outside an in-range pixel write");

  // A result is loaded only once the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("result loaded over a pending beat");
`endif

endmodule

### design/lmfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame scanner datapath
// Frame store with row valid bits, request capture, byte gathering for
// refresh and the result output register.
// ----------------------------------------------------------------------------
module lmfs_datapath (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     in_kind,
  input  logic [7:0]     in_x,
  input  logic [7:0]     in_y,
  input  logic           in_value,
  input  lmfs_pkg::cmd_t cmd,
  output lmfs_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           result_kind,
  output logic           pixel_bit,
  output logic           coord_ignored,
  output logic [3:0]     digit_register,
  output logic [7:0]     segment_data,
  output logic [2:0]     module_slot,
  output logic           last
);
  import lmfs_pkg::*;

  localparam logic [3:0] K_DONE = 4'(GROUP_ROWS);

  logic [1:0]        kind_r;
  logic [3:0]        x_r;
  logic [ADDR_W-1:0] y_r;
  logic              val_r;
  logic              bad_r;
  logic [2:0]        digit;
  logic [2:0]        slot;
  logic [3:0]        k;
  logic [ROWS-1:0]   vld;
  logic              rd_vld;
  logic [ADDR_W-1:0] raddr;
  logic [ROW_W-1:0]  rdata;
  logic [ROW_W-1:0]  row_cur;
  logic [ROW_W-1:0]  mask;
  logic [ROW_W-1:0]  wdata;
  logic [3:0]        bit_sel;
  logic              rbit;
  logic              gbit;
  logic [7:0]        seg;
  logic              word_last;

  // Request capture; a coordinate is out of range if any high bit is set.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      x_r    <= in_x[3:0];
      y_r    <= in_y[ADDR_W-1:0];
      val_r  <= in_value;
      bad_r  <= (|in_x[7:4]) || (|in_y[7:ADDR_W]);
    end
  end

  // Refresh counters: module slot inner, digit outer, row within group.
  always_ff @(posedge clk) begin
    if (rst || cmd.accept) begin
      digit <= '0;
      slot  <= '0;
      k     <= '0;
    end else if (cmd.ref_advance) begin
      k    <= '0;
      slot <= slot + 3'd1;
      if (slot == LAST_INDEX) begin
        digit <= digit + 3'd1;
      end
    end else if (cmd.gather_step && (k != K_DONE)) begin
      k <= k + 4'd1;
    end
  end

  // Row valid bits; a row never written since reset or clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_store) begin
      vld <= '0;
    end else if (cmd.wr_en) begin
      vld[y_r] <= 1'b1;
    end
  end

  // Read address: the request row, or the current row of a refresh group.
  assign raddr = (kind_r == KIND_REFRESH) ? {slot[1:0], k[2:0]} : y_r;

  always_ff @(posedge clk) begin
    rd_vld <= vld[raddr];
  end

  lmfs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (y_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Pixel x sits at bit 15-x of its row.
  assign row_cur = rd_vld ? rdata : '0;
  assign bit_sel = 4'(ROW_W - 1) - x_r;
  assign mask    = ROW_W'(1) << bit_sel;
  assign wdata   = val_r ? (row_cur | mask) : (row_cur & ~mask);
  assign rbit    = row_cur[bit_sel];

  // Refresh byte: high-half modules take bit digit+8; first row ends in bit 7.
  assign gbit = row_cur[{slot[2], digit}];

  always_ff @(posedge clk) begin
    if (cmd.gather_step && (k != 4'd0)) begin
      seg <= {seg[6:0], gbit};
    end
  end

  assign word_last = (digit == LAST_INDEX) && (slot == LAST_INDEX);

  // Status to the controller.
  always_comb begin
    sts.kind      = kind_r;
    sts.bad       = bad_r;
    sts.k_done    = (k == K_DONE);
    sts.word_last = word_last;
    sts.out_free  = !out_valid || out_ready;
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (kind_r == KIND_REFRESH) begin
        result_kind    <= 1'b1;
        pixel_bit      <= 1'b0;
        coord_ignored  <= 1'b0;
        digit_register <= {1'b0, digit} + 4'd1;
        segment_data   <= seg;
        module_slot    <= slot;
        last           <= word_last;
      end else begin
        result_kind    <= 1'b0;
        pixel_bit      <= (kind_r == KIND_READ) && !bad_r && rbit;
        coord_ignored  <= ((kind_r == KIND_WRITE) || (kind_r == KIND_READ)) && bad_r;
        digit_register <= '0;
        segment_data   <= '0;
        module_slot    <= '0;
        last           <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  // A clear empties every row at once.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_store |=> vld == '0)
    else $error("rows still marked valid after a clear");

  // A display word is emitted only once all eight rows are gathered.
  a_word_complete: assert property (@(posedge clk) disable iff (rst)
    cmd.load && (kind_r == KIND_REFRESH) |-> k == K_DONE)
    else $error("display word emitted before its byte was complete");

  // A written row becomes valid.
  a_write_marks: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |=> vld[$past(y_r)])
    else $error("written row not marked valid");
`endif

endmodule

### design/led_matrix_frame_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix frame scanner
// 32 x 16 monochrome frame store with pixel write, pixel read, clear and a
// refresh that emits 64 display words for eight chained 8x8 driver modules.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  req      in         kind, x_pos, y_pos, pixel_value
//  rsp      out        result_kind, pixel_bit, coord_ignored, digit_register,
//                      segment_data, module_slot, last
//
// A pixel write, read or clear gives one beat, and a refresh gives 64
// beats, one per display word; each byte needs eight rows through the
// single read port of the frame RAM. Reset clears the row valid bits,
// so the store reads as zero at once. A finished beat waits in the output
// register; a new request is taken while it waits, and work stalls only
// when the next beat finds it full.
// ----------------------------------------------------------------------------
module led_matrix_frame_scanner_unit (
  input logic        clk,
  input logic        rst,
  lmfs_req_if.sink   req,
  lmfs_rsp_if.source rsp
);
  import lmfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller.
  lmfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_kind  (req.kind),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  lmfs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .in_kind        (req.kind),
    .in_x           (req.x_pos),
    .in_y           (req.y_pos),
    .in_value       (req.pixel_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .result_kind    (rsp.result_kind),
    .pixel_bit      (rsp.pixel_bit),
    .coord_ignored  (rsp.coord_ignored),
    .digit_register (rsp.digit_register),
    .segment_data   (rsp.segment_data),
    .module_slot    (rsp.module_slot),
    .last           (rsp.last)
  );

endmodule

### tb/sv/tb_led_matrix_frame_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix frame scanner testbench
// Drives pixel writes, pixel reads, clears and refreshes into the scanner,
// and keeps a shadow of the 32 x 16 frame store. Every result beat is checked
// field by field against the words that the shadow store predicts. Both
// channels idle at random, with one stretch that runs at full rate.
// ----------------------------------------------------------------------------
module tb_led_matrix_frame_scanner_unit;
  import lmfs_pkg::*;

  // One result beat as the result channel carries it.
  typedef struct packed {
    logic       result_kind;
    logic       pixel_bit;
    logic       coord_ignored;
    logic [3:0] digit_register;
    logic [7:0] segment_data;
    logic [2:0] module_slot;
    logic       last;
  } scan_word_t;

  // Shadow frame store, prediction of the result beats and their checking.
  class frame_scoreboard;
    logic [15:0] shadow_rows [32];
    scan_word_t  pending_words [$];
    int          errors;

    function new();
      foreach (shadow_rows[i]) shadow_rows[i] = '0;
      errors = 0;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    // Eight rows of one column of one module, top row in the MSB.
    function logic [7:0] column_byte(int digit_idx, int slot);
      logic [7:0] data;
      int         base;
      int         col;
      data = '0;
      base = (slot % 4) * 8;
      col  = digit_idx + ((slot >= 4) ? 8 : 0);
      for (int k = 0; k < 8; k++) begin
        if (shadow_rows[base + k][col]) data[7 - k] = 1'b1;
      end
      return data;
    endfunction

    // Updates the shadow store for an accepted request and queues its beats.
    function void note_request(logic [1:0] kind, logic [7:0] x, logic [7:0] y,
                               logic value);
      scan_word_t word;
      logic       bad;
      bad  = (x > 8'd15) || (y > 8'd31);
      word = '0;
      word.last = 1'b1;
      case (kind)
        KIND_WRITE: begin
          if (!bad) shadow_rows[y[4:0]][15 - x[3:0]] = value;
          word.coord_ignored = bad;
          pending_words.push_back(word);
        end
        KIND_READ: begin
          if (!bad) word.pixel_bit = shadow_rows[y[4:0]][15 - x[3:0]];
          word.coord_ignored = bad;
          pending_words.push_back(word);
        end
        KIND_CLEAR: begin
          foreach (shadow_rows[i]) shadow_rows[i] = '0;
          pending_words.push_back(word);
        end
        default: begin
          for (int d = 0; d < 8; d++) begin
            for (int m = 0; m < 8; m++) begin
              word                = '0;
              word.result_kind    = 1'b1;
              word.digit_register = 4'(d + 1);
              word.segment_data   = column_byte(d, m);
              word.module_slot    = 3'(m);
              word.last           = (d == 7) && (m == 7);
              pending_words.push_back(word);
            end
          end
        end
      endcase
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    // Compares one result beat with the oldest queued word.
    function void check_result(scan_word_t got);
      scan_word_t want;
      if (pending_words.size() == 0) begin
        $error("result beat with nothing outstanding: %h", got);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("pixel_bit", want.pixel_bit, got.pixel_bit);
      compare_field("coord_ignored", want.coord_ignored, got.coord_ignored);
      compare_field("digit_register", want.digit_register, got.digit_register);
      compare_field("segment_data", want.segment_data, got.segment_data);
      compare_field("module_slot", want.module_slot, got.module_slot);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idle_on;

  lmfs_req_if req ();
  lmfs_rsp_if rsp ();

  frame_scoreboard board = new();

  led_matrix_frame_scanner_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // The result side stalls at random while idling is enabled.
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 26) begin
      rsp.ready = 1'b0;
    end else begin
      rsp.ready = 1'b1;
    end
  end

  // Both channels are sampled at the rising edge, where a beat is taken.
  always @(posedge clk) begin : monitor
    scan_word_t seen;
    if (!rst) begin
      if (req.valid && req.ready) begin
        board.note_request(req.kind, req.x_pos, req.y_pos, req.pixel_value);
      end
      if (rsp.valid && rsp.ready) begin
        seen.result_kind    = rsp.result_kind;
        seen.pixel_bit      = rsp.pixel_bit;
        seen.coord_ignored  = rsp.coord_ignored;
        seen.digit_register = rsp.digit_register;
        seen.segment_data   = rsp.segment_data;
        seen.module_slot    = rsp.module_slot;
        seen.last           = rsp.last;
        board.check_result(seen);
      end
    end
  end

  // Presents one request, after a random gap, and holds it until taken.
  task automatic send_request(logic [1:0] kind, logic [7:0] x, logic [7:0] y,
                              logic value);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 26) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid       = 1'b1;
    req.kind        = kind;
    req.x_pos       = x;
    req.y_pos       = y;
    req.pixel_value = value;
    do @(posedge clk); while (!req.ready);
  endtask

  // Random requests: mostly in-range pixel traffic, some refreshes and
  // clears, and a tenth of the pixel requests with a coordinate out of range.
  task automatic send_random(int count);
    int         pick;
    logic [1:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic       value;
    for (int n = 0; n < count; n++) begin
      pick  = $urandom_range(0, 99);
      x     = 8'($urandom_range(0, 15));
      y     = 8'($urandom_range(0, 31));
      value = ($urandom_range(0, 99) < 65);
      if (pick < 55) begin
        kind = KIND_WRITE;
      end else if (pick < 85) begin
        kind = KIND_READ;
      end else if (pick < 87) begin
        kind = KIND_CLEAR;
      end else begin
        kind = KIND_REFRESH;
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: x = 8'($urandom_range(16, 255));
          1: y = 8'($urandom_range(32, 255));
          default: begin
            x = 8'($urandom_range(16, 255));
            y = 8'($urandom_range(32, 255));
          end
        endcase
      end
      if (kind == KIND_CLEAR || kind == KIND_REFRESH) begin
        x     = 8'($urandom);
        y     = 8'($urandom);
        value = 1'($urandom);
      end
      send_request(kind, x, y, value);
    end
  endtask

  // Main sequence.
  initial begin
    idle_on         = 1'b1;
    rst             = 1'b1;
    req.valid       = 1'b0;
    req.kind        = KIND_WRITE;
    req.x_pos       = '0;
    req.y_pos       = '0;
    req.pixel_value = 1'b0;
    rsp.ready       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: corners, out-of-range coordinates, clear and refresh.
    send_request(KIND_REFRESH, 8'd0, 8'd0, 1'b0);
    send_request(KIND_WRITE, 8'd0, 8'd0, 1'b1);
    send_request(KIND_WRITE, 8'd15, 8'd31, 1'b1);
    send_request(KIND_WRITE, 8'd15, 8'd0, 1'b1);
    send_request(KIND_WRITE, 8'd0, 8'd31, 1'b1);
    send_request(KIND_WRITE, 8'd7, 8'd12, 1'b1);
    send_request(KIND_WRITE, 8'd8, 8'd20, 1'b1);
    send_request(KIND_WRITE, 8'd16, 8'd0, 1'b1);
    send_request(KIND_WRITE, 8'd0, 8'd32, 1'b1);
    send_request(KIND_WRITE, 8'd255, 8'd255, 1'b1);
    send_request(KIND_READ, 8'd0, 8'd0, 1'b0);
    send_request(KIND_READ, 8'd15, 8'd31, 1'b1);
    send_request(KIND_READ, 8'd1, 8'd1, 1'b0);
    send_request(KIND_READ, 8'd16, 8'd0, 1'b0);
    send_request(KIND_READ, 8'd0, 8'd255, 1'b0);
    send_request(KIND_REFRESH, 8'd255, 8'd255, 1'b1);
    send_request(KIND_WRITE, 8'd0, 8'd0, 1'b0);
    send_request(KIND_READ, 8'd0, 8'd0, 1'b1);
    send_request(KIND_CLEAR, 8'd255, 8'd255, 1'b1);
    send_request(KIND_READ, 8'd15, 8'd31, 1'b0);
    send_request(KIND_REFRESH, 8'd0, 8'd0, 1'b0);

    // Random part with idling on both sides.
    send_random(90);

    // Let the scanner drain completely before going on.
    @(negedge clk);
    req.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);

    // A stretch at full rate with no idling at all.
    idle_on = 1'b0;
    send_random(70);
    idle_on = 1'b1;
    send_random(100);

    @(negedge clk);
    req.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (board.errors == 0) begin
      $display("[led_matrix_frame_scanner_unit] OK");
    end else begin
      $display("[led_matrix_frame_scanner_unit] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40ms;
    $display("[led_matrix_frame_scanner_unit] ERROR");
    $finish;
  end

endmodule
